>>> rtl/lsfr_pkg.sv
// ----------------------------------------------------------------------------
// lsfr_pkg
// Shared types, constants and helpers for the letter-skip find/replace block.
// ----------------------------------------------------------------------------
package lsfr_pkg;

  localparam int unsigned PATTERN_MAX  = 16;
  localparam int unsigned REPLACE_MAX  = 16;
  localparam int unsigned WINDOW_DEPTH = 32;
  localparam int unsigned RESULT_CAP   = 48;

  // window ring holds candidate plus rescan bytes, never more than WINDOW_DEPTH+1
  localparam int unsigned WIN_SLOTS = 2 * WINDOW_DEPTH;
  localparam int unsigned PTR_W     = $clog2(WIN_SLOTS);
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned RES_W     = $clog2(RESULT_CAP + 1);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_PAT_LO   = 3'd0,
    REG_PAT_HI   = 3'd1,
    REG_PAT_LEN  = 3'd2,
    REG_REP_LO   = 3'd3,
    REG_REP_HI   = 3'd4,
    REG_REP_LEN  = 3'd5,
    REG_OUT_LIM  = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_idx_e;

  // command passed from matcher to emitter
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_REPL = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       eot;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_RUN  = 2'd1,
    F_EVAL = 2'd2,
    F_FAIL = 2'd3
  } front_state_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_REPL = 1'b1
  } back_state_e;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_DELTA : c;
  endfunction

  // byte k of a 16-byte string held as two 64-bit words
  function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [3:0] k);
    logic [127:0] all;
    all = {hi, lo};
    return all[{k, 3'b000} +: 8];
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] max);
    return (len > max) ? max : len;
  endfunction

endpackage

>>> rtl/lsfr_front.sv
// ----------------------------------------------------------------------------
// lsfr_front
// Matcher: accepts text bytes into a window ring, walks the candidate and
// issues byte / replacement / end-of-step commands.
// ----------------------------------------------------------------------------
module lsfr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_eot_i,
  input  logic [63:0]        pat_lo_i,
  input  logic [63:0]        pat_hi_i,
  input  logic [4:0]         pat_len_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output lsfr_pkg::cmd_t     cmd_o
);
  import lsfr_pkg::*;

  front_state_e     state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d, scan_q, scan_d, tail_q, tail_d;
  logic [4:0]       letters_q, letters_d;
  logic             eot_q, eot_d;
  logic [7:0]       rd_data_q;
  logic             rd_en, wr_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] pending;
  logic [4:0]       plen;
  logic             c_letter, c_match;

  logic [7:0] win_mem [WIN_SLOTS];

  // window ring: write at tail, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[tail_q] <= in_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= win_mem[rd_addr];
    end
  end

  assign pending  = scan_q - head_q;
  assign plen     = sat_len(pat_len_i, LEN_W'(PATTERN_MAX));
  assign c_letter = is_letter(rd_data_q);
  assign c_match  = c_letter &&
                    (fold(rd_data_q) == fold(byte_of(pat_lo_i, pat_hi_i, letters_q[3:0])));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      head_q    <= '0;
      scan_q    <= '0;
      tail_q    <= '0;
      letters_q <= '0;
      eot_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      scan_q    <= scan_d;
      tail_q    <= tail_d;
      letters_q <= letters_d;
      eot_q     <= eot_d;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    scan_d      = scan_q;
    tail_d      = tail_q;
    letters_d   = letters_q;
    eot_d       = eot_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q;
    wr_en       = 1'b0;
    in_ready_o  = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_BYTE;
    cmd_o.data  = rd_data_q;
    cmd_o.eot   = eot_q;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          wr_en   = 1'b1;
          tail_d  = tail_q + 1'b1;
          eot_d   = in_eot_i;
          state_d = F_RUN;
        end
      end
      F_RUN: begin
        if (scan_q != tail_q) begin
          rd_en = 1'b1;
          if (pending >= PTR_W'(WINDOW_DEPTH)) begin
            rd_addr = head_q;
            state_d = F_FAIL;
          end else begin
            state_d = F_EVAL;
          end
        end else if (eot_q && (pending != '0)) begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = F_FAIL;
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_END;
          if (cmd_ready_i) begin
            state_d = F_IDLE;
          end
        end
      end
      F_EVAL: begin
        if (pending == '0) begin
          if ((plen != '0) && c_match) begin
            if (plen == 5'd1) begin
              cmd_valid_o = 1'b1;
              cmd_o.kind  = CMD_REPL;
              if (cmd_ready_i) begin
                head_d  = scan_q + 1'b1;
                scan_d  = scan_q + 1'b1;
                state_d = F_RUN;
              end
            end else begin
              scan_d    = scan_q + 1'b1;
              letters_d = 5'd1;
              state_d   = F_RUN;
            end
          end else begin
            cmd_valid_o = 1'b1;
            if (cmd_ready_i) begin
              head_d  = scan_q + 1'b1;
              scan_d  = scan_q + 1'b1;
              state_d = F_RUN;
            end
          end
        end else if (!c_letter) begin
          // skipped non-letter joins the span
          scan_d  = scan_q + 1'b1;
          state_d = F_RUN;
        end else if (c_match) begin
          if ((letters_q + 5'd1) >= plen) begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_REPL;
            if (cmd_ready_i) begin
              head_d    = scan_q + 1'b1;
              scan_d    = scan_q + 1'b1;
              letters_d = '0;
              state_d   = F_RUN;
            end
          end else begin
            scan_d    = scan_q + 1'b1;
            letters_d = letters_q + 5'd1;
            state_d   = F_RUN;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = F_FAIL;
        end
      end
      F_FAIL: begin
        // emit candidate's first byte, rescan from the next one
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          head_d    = head_q + 1'b1;
          scan_d    = head_q + 1'b1;
          letters_d = '0;
          state_d   = F_RUN;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

>>> rtl/lsfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lsfr_cmd_fifo
// Short command queue between matcher and emitter.
// ----------------------------------------------------------------------------
module lsfr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsfr_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output lsfr_pkg::cmd_t pop_cmd_o
);
  import lsfr_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  cmd_t          slots_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != (AW + 1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

>>> rtl/lsfr_back.sv
// ----------------------------------------------------------------------------
// lsfr_back
// Emitter: expands commands into output bytes, applies the output limit and
// the per-step cap, and marks the last byte of each step.
// ----------------------------------------------------------------------------
module lsfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  lsfr_pkg::cmd_t cmd_i,
  input  logic [63:0]    rep_lo_i,
  input  logic [63:0]    rep_hi_i,
  input  logic [4:0]     rep_len_i,
  input  logic [7:0]     out_limit_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_done_o
);
  import lsfr_pkg::*;

  back_state_e      state_q, state_d;
  logic             held_valid_q, held_valid_d;
  logic [7:0]       held_byte_q, held_byte_d;
  logic [RES_W-1:0] res_cnt_q, res_cnt_d;
  logic [7:0]       sent_q, sent_d;
  logic [3:0]       k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d, out_done_q, out_done_d;
  logic             out_free, allowed, emit_req, emit_done;
  logic [7:0]       emit_byte;
  logic [4:0]       rlen;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  assign rlen      = sat_len(rep_len_i, LEN_W'(REPLACE_MAX));
  assign out_free  = !out_valid_q || out_ready_i;
  assign allowed   = (res_cnt_q < RES_W'(RESULT_CAP)) && (sent_q < out_limit_i);
  assign emit_done = !allowed || !held_valid_q || out_free;

  // output payload
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    held_byte_q <= held_byte_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      held_valid_q <= 1'b0;
      res_cnt_q    <= '0;
      sent_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      res_cnt_q    <= res_cnt_d;
      sent_q       <= sent_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // command execution; one byte is held back until the next one or the
  // end of the step decides its last mark
  always_comb begin
    state_d      = state_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    res_cnt_d    = res_cnt_q;
    sent_d       = sent_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    cmd_pop_o    = 1'b0;
    emit_req     = 1'b0;
    emit_byte    = cmd_i.data;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_BYTE: begin
              emit_req  = 1'b1;
              cmd_pop_o = emit_done;
            end
            CMD_REPL: begin
              if (rlen == '0) begin
                cmd_pop_o = 1'b1;
              end else begin
                k_d     = '0;
                state_d = B_REPL;
              end
            end
            CMD_END: begin
              if (!held_valid_q || out_free) begin
                if (held_valid_q) begin
                  out_valid_d  = 1'b1;
                  out_byte_d   = held_byte_q;
                  out_last_d   = 1'b1;
                  out_done_d   = cmd_i.eot;
                  held_valid_d = 1'b0;
                end
                res_cnt_d = '0;
                if (cmd_i.eot) sent_d = '0;
                cmd_pop_o = 1'b1;
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      B_REPL: begin
        emit_req  = 1'b1;
        emit_byte = byte_of(rep_lo_i, rep_hi_i, k_q);
        if (emit_done) begin
          if (({1'b0, k_q} + 5'd1) >= rlen) begin
            cmd_pop_o = 1'b1;
            state_d   = B_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase

    // shared emit path
    if (emit_req && allowed && emit_done) begin
      if (held_valid_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = held_byte_q;
        out_last_d  = 1'b0;
        out_done_d  = 1'b0;
      end
      held_valid_d = 1'b1;
      held_byte_d  = emit_byte;
      res_cnt_d    = res_cnt_q + 1'b1;
      sent_d       = sent_q + 1'b1;
    end
  end

endmodule

>>> rtl/letter_skip_find_replace.sv
// ----------------------------------------------------------------------------
// letter_skip_find_replace
// Case-insensitive find/replace over a byte stream with letter skipping.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata / data          | tlast       | tuser
//  s_axis    | in  | [7:0] text_byte       | end_of_text | -
//  m_axis    | out | [7:0] out_byte        | run_last    | text_done
//  apb       | in  | 64-bit regs at 8*i    | -           | -
//
//  A byte that passes straight through takes the matcher steps accept, window
//  read, evaluate, end-of-step command; each further byte scanned adds a read
//  and an evaluate, a failed candidate a fail step and a rescan of its bytes.
//  Replacements leave the emitter at one byte per cycle unless output stalls.
//  The window ring has a single read port, which sets the matcher rate.
//  Reset clears pointers and counters; the window needs no clearing.
//  Either side may stall independently through the four-entry command queue.
// ----------------------------------------------------------------------------
module letter_skip_find_replace (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] text_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import lsfr_pkg::*;

  logic [63:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [4:0]  pat_len_q, rep_len_q;
  logic [7:0]  out_limit_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;
  logic        f_cmd_valid, f_cmd_ready, q_valid, q_pop;
  cmd_t        f_cmd, q_cmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q    <= '0;
      pat_hi_q    <= '0;
      pat_len_q   <= '0;
      rep_lo_q    <= '0;
      rep_hi_q    <= '0;
      rep_len_q   <= '0;
      out_limit_q <= 8'd199;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAT_LO:  pat_lo_q    <= pwdata;
        REG_PAT_HI:  pat_hi_q    <= pwdata;
        REG_PAT_LEN: pat_len_q   <= pwdata[4:0];
        REG_REP_LO:  rep_lo_q    <= pwdata;
        REG_REP_HI:  rep_hi_q    <= pwdata;
        REG_REP_LEN: rep_len_q   <= pwdata[4:0];
        REG_OUT_LIM: out_limit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_PAT_LO:  prdata = pat_lo_q;
      REG_PAT_HI:  prdata = pat_hi_q;
      REG_PAT_LEN: prdata = {59'd0, pat_len_q};
      REG_REP_LO:  prdata = rep_lo_q;
      REG_REP_HI:  prdata = rep_hi_q;
      REG_REP_LEN: prdata = {59'd0, rep_len_q};
      REG_OUT_LIM: prdata = {56'd0, out_limit_q};
      default:     prdata = '0;
    endcase
  end

  lsfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eot_i    (s_axis_tlast),
    .pat_lo_i    (pat_lo_q),
    .pat_hi_i    (pat_hi_q),
    .pat_len_i   (pat_len_q),
    .cmd_valid_o (f_cmd_valid),
    .cmd_ready_i (f_cmd_ready),
    .cmd_o       (f_cmd)
  );

  lsfr_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_cmd_valid),
    .push_ready_o (f_cmd_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  lsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .rep_lo_i    (rep_lo_q),
    .rep_hi_i    (rep_hi_q),
    .rep_len_i   (rep_len_q),
    .out_limit_i (out_limit_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

endmodule

>>> test/tb_letter_skip_find_replace.sv
// ----------------------------------------------------------------------------
// tb_letter_skip_find_replace
// Streams text through the find/replace block under several pattern,
// replacement and output-limit settings. A local predictor computes the
// rewritten bytes, and the monitor checks each output transfer in order.
// ----------------------------------------------------------------------------
module tb_letter_skip_find_replace;
  import lsfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  letter_skip_find_replace u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and matcher state
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [4:0]  pat_len_r, rep_len_r;
  logic [7:0]  out_lim;
  logic [7:0]  win_bytes [WINDOW_DEPTH];
  int unsigned win_count, letters_hit, emitted_count;
  int unsigned step_count;
  logic        step_eot;

  text_item_t  pending_items [$];
  out_item_t   expected_bytes [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          stream_en = 1'b0;
  int          src_gap = 0;
  int          sink_gap = 0;

  function automatic bit letter_p(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] lower_p(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] str_byte(logic [63:0] lo, logic [63:0] hi, int k);
    logic [127:0] s;
    s = {hi, lo};
    return s[k*8 +: 8];
  endfunction

  task automatic push_byte(logic [7:0] b);
    out_item_t r;
    if (step_count >= RESULT_CAP || emitted_count >= out_lim) return;
    r.out_byte = b; r.run_last = 1'b0; r.text_done = 1'b0;
    expected_bytes.push_back(r);
    step_count++;
    emitted_count++;
  endtask

  task automatic push_replacement();
    int n;
    n = (rep_len_r > REPLACE_MAX) ? REPLACE_MAX : rep_len_r;
    for (int k = 0; k < n; k++) push_byte(str_byte(rep_lo, rep_hi, k));
  endtask

  // one text byte through the matcher, with rescan of failed candidates
  task automatic predict_rewrite(text_item_t it);
    logic [7:0] q [$];
    logic [7:0] c;
    int plen;
    bit fail;
    int base;
    q.push_back(it.text_byte);
    plen = (pat_len_r > PATTERN_MAX) ? PATTERN_MAX : pat_len_r;
    step_count = 0;
    base = expected_bytes.size();
    while (q.size() > 0 || (it.end_of_text && win_count > 0)) begin
      fail = 1'b0;
      if (q.size() > 0) begin
        c = q[0];
        if (win_count == 0) begin
          void'(q.pop_front());
          if (plen > 0 && letter_p(c) && lower_p(c) == lower_p(str_byte(pat_lo, pat_hi, 0))) begin
            if (plen == 1) push_replacement();
            else begin
              win_bytes[0] = c; win_count = 1; letters_hit = 1;
            end
          end else push_byte(c);
          continue;
        end
        if (win_count >= WINDOW_DEPTH) fail = 1'b1;
        else if (!letter_p(c)) begin
          win_bytes[win_count] = c;
          win_count++;
          void'(q.pop_front());
        end else if (letters_hit < plen &&
                     lower_p(c) == lower_p(str_byte(pat_lo, pat_hi, letters_hit))) begin
          void'(q.pop_front());
          letters_hit++;
          if (letters_hit >= plen) begin
            push_replacement();
            win_count = 0; letters_hit = 0;
          end else begin
            win_bytes[win_count] = c;
            win_count++;
          end
        end else fail = 1'b1;
      end else fail = 1'b1;
      if (fail) begin
        for (int k = win_count - 1; k >= 1; k--) q.push_front(win_bytes[k]);
        push_byte(win_bytes[0]);
        win_count = 0; letters_hit = 0;
      end
    end
    if (expected_bytes.size() > base) begin
      expected_bytes[$].run_last = 1'b1;
      expected_bytes[$].text_done = it.end_of_text;
    end
    if (it.end_of_text) begin
      win_count = 0; letters_hit = 0; emitted_count = 0;
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // driver: source side from the pending queue
  always @(posedge clk_i) begin
    text_item_t it;
    cycle_count <= cycle_count + 1;
    if (s_axis_tvalid && s_axis_tready) predict_rewrite({s_axis_tdata, s_axis_tlast});
    if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_items.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (stream_en && pending_items.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                   && pending_items.size() > 0) begin
        it = pending_items[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.text_byte;
        s_axis_tlast <= it.end_of_text;
        src_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // monitor: sink side with random stalls and one long hold-off
  always @(posedge clk_i) begin
    out_item_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected", m_axis_tdata, 8'h00);
      end else begin
        w = expected_bytes.pop_front();
        if (m_axis_tdata !== w.out_byte) report_mismatch("out_byte", m_axis_tdata, w.out_byte);
        if (m_axis_tlast !== w.run_last) report_mismatch("run_last", m_axis_tlast, w.run_last);
        if (m_axis_tuser !== w.text_done) report_mismatch("text_done", m_axis_tuser, w.text_done);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PAT_LO:  pat_lo = val;
      REG_PAT_HI:  pat_hi = val;
      REG_PAT_LEN: pat_len_r = val[4:0];
      REG_REP_LO:  rep_lo = val;
      REG_REP_HI:  rep_hi = val;
      REG_REP_LEN: rep_len_r = val[4:0];
      REG_OUT_LIM: out_lim = val[7:0];
      default: ;
    endcase
  endtask

  // pack a letter string (mixed case on request) into two words
  function automatic logic [127:0] pack_text(string s, bit mix);
    logic [127:0] v;
    logic [7:0] c;
    v = '0;
    for (int k = 0; k < s.len() && k < 16; k++) begin
      c = s[k];
      if (mix && letter_p(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
      v[k*8 +: 8] = c;
    end
    return v;
  endfunction

  task automatic set_config(string pat, bit mix, logic [4:0] plen, logic [127:0] rep,
                            logic [4:0] rlen, logic [7:0] lim);
    logic [127:0] p;
    p = pack_text(pat, mix);
    write_reg(REG_PAT_LO, p[63:0]);
    write_reg(REG_PAT_HI, p[127:64]);
    write_reg(REG_PAT_LEN, {59'd0, plen});
    write_reg(REG_REP_LO, rep[63:0]);
    write_reg(REG_REP_HI, rep[127:64]);
    write_reg(REG_REP_LEN, {59'd0, rlen});
    write_reg(REG_OUT_LIM, {56'd0, lim});
  endtask

  task automatic add_text(string s, bit eot);
    for (int k = 0; k < s.len(); k++)
      pending_items.push_back({s[k], eot && (k == s.len() - 1)});
  endtask

  // text rich in pattern copies with skipped non-letters and near misses
  task automatic add_random_text(string pat, int count);
    logic [7:0] c;
    int k;
    k = 0;
    while (k < count) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          for (int j = 0; j < pat.len() && k < count; j++) begin
            c = pat[j];
            if ($urandom_range(0, 1)) c = c ^ 8'h20;
            if ($urandom_range(0, 15) == 0) c = $urandom_range(0, 255);
            pending_items.push_back({c, 1'b0}); k++;
            if ($urandom_range(0, 4) == 0 && k < count) begin
              pending_items.push_back({8'($urandom_range(32, 64)), 1'b0}); k++;
            end
          end
        end
        default: begin
          pending_items.push_back({8'($urandom_range(0, 255)), $urandom_range(0, 20) == 0});
          k++;
        end
      endcase
    end
    pending_items.push_back({8'($urandom_range(0, 255)), 1'b1});
  endtask

  task automatic run_phase();
    stream_en = 1'b1;
    while ((pending_items.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
           && cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    stream_en = 1'b0;
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    pat_lo = '0; pat_hi = '0; rep_lo = '0; rep_hi = '0;
    pat_len_r = '0; rep_len_r = '0; out_lim = 8'd199;
    win_count = 0; letters_hit = 0; emitted_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset settings: no pattern, every byte passes, byte extremes
    pending_items.push_back({8'h00, 1'b0});
    pending_items.push_back({8'hFF, 1'b0});
    add_text("Az", 1'b1);
    run_phase();

    // short pattern with skipped punctuation, a failed candidate, window overflow
    set_config("cat", 1'b1, 5'd3, pack_text("DOG!", 1'b0), 5'd4, 8'd199);
    add_text("C.a-T caX cccat", 1'b0);
    add_text({"c", {40{"."}}, "at"}, 1'b1);
    add_text("1cat", 1'b1);
    run_phase();

    // single letter pattern, empty replacement, tiny output limit
    set_config("z", 1'b0, 5'd1, '0, 5'd0, 8'd3);
    add_text("aZbzcdefg", 1'b1);
    run_phase();

    // oversized lengths saturate, full 16-letter pattern; long hold-off on the sink
    set_config("abcdefghijklmnop", 1'b1, 5'd31, {16{8'hA5}}, 5'd31, 8'd255);
    add_text("abcdefghijklmnop", 1'b0);
    add_random_text("abcdefghijklmnop", 20);
    hold_cycles = 400;
    run_phase();

    // non-letter in pattern never matches; output limit zero drops everything
    set_config("a1b", 1'b0, 5'd3, pack_text("xy", 1'b0), 5'd2, 8'd0);
    add_text("a1b a1b", 1'b1);
    run_phase();

    // random mid settings
    set_config("ok", 1'b1, 5'd2, {$urandom, $urandom, $urandom, $urandom}, 5'd5, 8'd40);
    add_random_text("ok", 25);
    run_phase();
    set_config("hello", 1'b1, 5'd5, {$urandom, $urandom, $urandom, $urandom}, 5'd16, 8'd255);
    add_random_text("hello", 30);
    run_phase();

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("letter_skip_find_replace verification failed");
    end else if (error_count == 0) begin
      $display("letter_skip_find_replace verification clean");
    end else begin
      $display("letter_skip_find_replace verification failed");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT + 100) begin
      $display("letter_skip_find_replace verification failed");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/lsfr_pkg.sv
rtl/lsfr_front.sv
rtl/lsfr_cmd_fifo.sv
rtl/lsfr_back.sv
rtl/letter_skip_find_replace.sv
test/tb_letter_skip_find_replace.sv
